FILE: design/mda_pkg.sv
// Package: constants, types and the arctangent table for the direction-angle pipeline.
package mda_pkg;

  localparam int MomW       = 24;
  localparam int FracBits   = 10;
  localparam int IntAngBits = 24;
  localparam int NormBit    = 40;
  localparam int Steps      = 28;
  // datapath width: normalized magnitudes stay below 2^41, CORDIC growth under 2^43
  localparam int DW         = 45;
  localparam int AW         = 34;
  localparam int PolW       = 18;
  localparam int AzW        = 19;
  localparam int PosW       = 6;

  localparam logic [31:0] InvGain = 32'd10188014;
  localparam logic signed [AW-1:0] Deg90  = AW'(64'sd1509949440);
  localparam logic signed [AW-1:0] Deg180 = AW'(64'sd3019898880);

  typedef logic signed [DW-1:0] dat_t;
  typedef logic signed [AW-1:0] ang_t;

  // atan(2^-i) in 2^-24 degree
  function automatic ang_t atan_tab(input int i);
    ang_t r;
    r = '0;
    case (i)
      0: r = AW'(754974720);   1: r = AW'(445687602);
      2: r = AW'(235489088);   3: r = AW'(119537938);
      4: r = AW'(60000934);    5: r = AW'(30029717);
      6: r = AW'(15018523);    7: r = AW'(7509720);
      8: r = AW'(3754917);     9: r = AW'(1877466);
      10: r = AW'(938734);     11: r = AW'(469367);
      12: r = AW'(234684);     13: r = AW'(117342);
      14: r = AW'(58671);      15: r = AW'(29335);
      16: r = AW'(14668);      17: r = AW'(7334);
      18: r = AW'(3667);       19: r = AW'(1833);
      20: r = AW'(917);        21: r = AW'(458);
      22: r = AW'(229);        23: r = AW'(115);
      24: r = AW'(57);         25: r = AW'(29);
      26: r = AW'(14);         27: r = AW'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp to [0, 90] degrees
  function automatic ang_t clamp90(input ang_t a);
    ang_t r;
    r = a;
    if (a < 0) r = '0;
    if (a > Deg90) r = Deg90;
    return r;
  endfunction

  // round half up to the output unit
  function automatic logic [AW-1:0] rnd(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    r = (v + (AW'(1) << (IntAngBits - FracBits - 1))) >> (IntAngBits - FracBits);
    return r;
  endfunction

  // per-item side info carried down the pipeline
  typedef struct packed {
    logic zero;
    logic nx;
    logic ny;
    logic nz;
    logic ax_nz;
    logic axy_nz;
    logic ay_nz;
    logic az_nz;
  } side_t;

endpackage

FILE: design/momentum_direction_angles_top.sv
// Top level: pipelined cartesian-to-spherical direction angles (two CORDIC passes).
// Register stages: 2 normalize, 28 + 28 CORDIC, 2 gain, 2 fold/round.
// Throughput: one word per cycle; every stage advances when the output register is free.
// A stall holds the whole pipeline; nothing is dropped or repeated.
// Reset: rst_n synchronous active low clears the valid bits; payload is not reset.
module momentum_direction_angles_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [mda_pkg::MomW-1:0] in_mom_x,
  input  logic signed [mda_pkg::MomW-1:0] in_mom_y,
  input  logic signed [mda_pkg::MomW-1:0] in_mom_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mda_pkg::PolW-1:0]      out_polar_angle,
  output logic signed [mda_pkg::AzW-1:0] out_azimuth_angle,
  output logic                          out_zero_vector
);

  localparam int S  = mda_pkg::Steps;
  localparam int NS = 2 * S + 6;
  localparam int MW = mda_pkg::MomW;
  localparam int DW = mda_pkg::DW;

  logic adv;
  logic [NS-1:0] vld_r;
  assign adv      = !vld_r[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[NS-1];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // stage 0: magnitudes and leading-one position
  logic [MW-1:0] mx0, my0, mz0, mmax;
  logic [mda_pkg::PosW-1:0] p0;
  always_comb begin
    mx0 = in_mom_x[MW-1] ? MW'(-in_mom_x) : in_mom_x;
    my0 = in_mom_y[MW-1] ? MW'(-in_mom_y) : in_mom_y;
    mz0 = in_mom_z[MW-1] ? MW'(-in_mom_z) : in_mom_z;
    mmax = mx0 | my0 | mz0;
    p0 = '0;
    for (int i = 0; i < MW; i++) begin
      if (mmax[i]) p0 = mda_pkg::PosW'(i);
    end
  end

  logic [MW-1:0] ax_r, ay_r, az_r;
  logic [mda_pkg::PosW-1:0] p_r;
  mda_pkg::side_t sd0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r <= mx0; ay_r <= my0; az_r <= mz0; p_r <= p0;
      sd0_r.zero   <= (mmax == '0);
      sd0_r.nx     <= in_mom_x[MW-1];
      sd0_r.ny     <= in_mom_y[MW-1];
      sd0_r.nz     <= in_mom_z[MW-1];
      sd0_r.ax_nz  <= (mx0 != '0);
      sd0_r.ay_nz  <= (my0 != '0);
      sd0_r.az_nz  <= (mz0 != '0);
      sd0_r.axy_nz <= (mx0 != '0) || (my0 != '0);
    end
  end

  // stage 1: normalize so the leading one sits at bit 40
  logic [mda_pkg::PosW-1:0] sh;
  assign sh = mda_pkg::PosW'(mda_pkg::NormBit) - p_r;
  mda_pkg::dat_t nx1_r, ny1_r, nz1_r;
  mda_pkg::side_t sd1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      nx1_r <= DW'({{(DW-MW){1'b0}}, ax_r}) <<< sh;
      ny1_r <= DW'({{(DW-MW){1'b0}}, ay_r}) <<< sh;
      nz1_r <= DW'({{(DW-MW){1'b0}}, az_r}) <<< sh;
      sd1_r <= sd0_r;
    end
  end

  // CORDIC pass one on (|x|, |y|)
  mda_pkg::dat_t a1_r [S+1];
  mda_pkg::dat_t b1_r [S+1];
  mda_pkg::ang_t c1_r [S+1];
  mda_pkg::dat_t z1_r [S+1];
  mda_pkg::side_t s1_r [S+1];
  always_comb begin
    a1_r[0] = nx1_r; b1_r[0] = ny1_r; c1_r[0] = '0;
    z1_r[0] = nz1_r; s1_r[0] = sd1_r;
  end
  for (genvar i = 0; i < S; i++) begin : g_p1
    always_ff @(posedge clk) begin
      if (adv) begin
        if (b1_r[i] >= 0) begin
          a1_r[i+1] <= a1_r[i] + (b1_r[i] >>> i);
          b1_r[i+1] <= b1_r[i] - (a1_r[i] >>> i);
          c1_r[i+1] <= c1_r[i] + mda_pkg::atan_tab(i);
        end else begin
          a1_r[i+1] <= a1_r[i] - (b1_r[i] >>> i);
          b1_r[i+1] <= b1_r[i] + (a1_r[i] >>> i);
          c1_r[i+1] <= c1_r[i] - mda_pkg::atan_tab(i);
        end
        z1_r[i+1] <= z1_r[i];
        s1_r[i+1] <= s1_r[i];
      end
    end
  end

  // gain stage A: split products with 1/K
  logic [63:0] hi_r, lo_r;
  mda_pkg::ang_t phiq_r;
  mda_pkg::dat_t zg_r;
  mda_pkg::side_t sg_r;
  logic [DW-1:0] ul;
  assign ul = a1_r[S];
  always_ff @(posedge clk) begin
    if (adv) begin
      hi_r   <= 64'(ul[DW-1:24]) * 64'(mda_pkg::InvGain);
      lo_r   <= 64'(ul[23:0]) * 64'(mda_pkg::InvGain);
      phiq_r <= mda_pkg::clamp90(c1_r[S]);
      zg_r   <= z1_r[S];
      sg_r   <= s1_r[S];
    end
  end

  // gain stage B: exact-axis selects for phi and r_xy
  // (normalized values nonzero iff raw values nonzero, since shifted values stay within 41 bits)
  mda_pkg::dat_t rxy_r, zb_r;
  mda_pkg::ang_t phi_r;
  mda_pkg::side_t sb_r;
  mda_pkg::dat_t nxd_r [S+2];
  mda_pkg::dat_t nyd_r [S+2];
  always_comb begin
    nxd_r[0] = nx1_r; nyd_r[0] = ny1_r;
  end
  for (genvar i = 0; i < S + 1; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        nxd_r[i+1] <= nxd_r[i];
        nyd_r[i+1] <= nyd_r[i];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r <= sg_r;
      zb_r <= zg_r;
      if (!sg_r.axy_nz) begin
        phi_r <= '0; rxy_r <= '0;
      end else if (!sg_r.ay_nz) begin
        phi_r <= '0; rxy_r <= nxd_r[S+1];
      end else if (!sg_r.ax_nz) begin
        phi_r <= mda_pkg::Deg90; rxy_r <= nyd_r[S+1];
      end else begin
        phi_r <= phiq_r;
        rxy_r <= DW'(hi_r + (lo_r >> 24));
      end
    end
  end

  // CORDIC pass two on (|z|, r_xy)
  mda_pkg::dat_t a2_r [S+1];
  mda_pkg::dat_t b2_r [S+1];
  mda_pkg::ang_t c2_r [S+1];
  mda_pkg::ang_t f2_r [S+1];
  mda_pkg::side_t s2_r [S+1];
  logic r0_r [S+1];
  always_comb begin
    a2_r[0] = zb_r; b2_r[0] = rxy_r; c2_r[0] = '0;
    f2_r[0] = phi_r; s2_r[0] = sb_r; r0_r[0] = (rxy_r == '0);
  end
  for (genvar i = 0; i < S; i++) begin : g_p2
    always_ff @(posedge clk) begin
      if (adv) begin
        if (b2_r[i] >= 0) begin
          a2_r[i+1] <= a2_r[i] + (b2_r[i] >>> i);
          b2_r[i+1] <= b2_r[i] - (a2_r[i] >>> i);
          c2_r[i+1] <= c2_r[i] + mda_pkg::atan_tab(i);
        end else begin
          a2_r[i+1] <= a2_r[i] - (b2_r[i] >>> i);
          b2_r[i+1] <= b2_r[i] + (a2_r[i] >>> i);
          c2_r[i+1] <= c2_r[i] - mda_pkg::atan_tab(i);
        end
        f2_r[i+1] <= f2_r[i];
        s2_r[i+1] <= s2_r[i];
        r0_r[i+1] <= r0_r[i];
      end
    end
  end

  // fold stage: quadrant fold back
  mda_pkg::ang_t th_r, ph_r;
  mda_pkg::side_t sf_r;
  mda_pkg::ang_t thq;
  always_comb begin
    if (r0_r[S]) thq = '0;
    else if (!s2_r[S].az_nz) thq = mda_pkg::Deg90;
    else thq = mda_pkg::clamp90(c2_r[S]);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sf_r <= s2_r[S];
      th_r <= s2_r[S].nz ? mda_pkg::Deg180 - thq : thq;
      ph_r <= (s2_r[S].ax_nz && s2_r[S].nx) ? mda_pkg::Deg180 - f2_r[S] : f2_r[S];
    end
  end

  // output register: round and sign
  logic [mda_pkg::AW-1:0] tm, pm;
  assign tm = mda_pkg::rnd(th_r);
  assign pm = mda_pkg::rnd(ph_r);
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sf_r.zero) begin
        out_polar_angle   <= '0;
        out_azimuth_angle <= '0;
        out_zero_vector   <= 1'b1;
      end else begin
        out_polar_angle   <= tm[mda_pkg::PolW-1:0];
        out_azimuth_angle <= (sf_r.ny && sf_r.axy_nz) ? mda_pkg::AzW'(-pm) :
                             mda_pkg::AzW'(pm);
        out_zero_vector   <= 1'b0;
      end
    end
  end

endmodule

FILE: design/mda_checker.sv
// Checker: port-level properties of the direction-angle block, bound to the top level.
module mda_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mda_pkg::PolW-1:0]       out_polar_angle,
  input logic signed [mda_pkg::AzW-1:0] out_azimuth_angle,
  input logic                           out_zero_vector
);

  // zero vector reports both angles as zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_vector |-> out_polar_angle == '0 && out_azimuth_angle == '0)
    else $error("zero vector with nonzero angle");

  // theta never beyond 180 degrees
  a_pol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_polar_angle <= mda_pkg::PolW'(184320))
    else $error("polar angle out of range");

  // input side stalls only while output is held
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // stalled word stays valid and its polar angle holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_polar_angle))
    else $error("output word changed while stalled");

endmodule

bind momentum_direction_angles_top mda_checker u_mda_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_polar_angle(out_polar_angle),
  .out_azimuth_angle(out_azimuth_angle), .out_zero_vector(out_zero_vector)
);
